// File: hdl/vib_pkg.sv
// ----------------------------------------------------------------------------
// vib_pkg
// shared types, codes and sizes of the vertex index batcher
// ----------------------------------------------------------------------------
package vib_pkg;

  localparam int unsigned VB_DEPTH  = 1024;
  localparam int unsigned MAX_POLY  = 8;
  localparam int unsigned IDX_LIMIT = VB_DEPTH * 6;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATE_W  = 32;
  localparam int unsigned PV_W     = 4;
  localparam int unsigned ID_W     = 12;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned MESH_W   = 13;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned CAP_W    = 11;
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned EPOCH_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [PV_W-1:0]  POS_MAX   = 4'hF;

  localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MESH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INDEX  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [STATE_W-1:0]  render_state;
    logic                first_in_polygon;
    logic [PV_W-1:0]     poly_vertices;
    logic                in_table;
    logic [ID_W-1:0]     vertex_id;
    logic [HANDLE_W-1:0] vertex_handle;
    logic [MESH_W-1:0]   mesh_vertices;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle_out;
    logic [CAP_W-1:0]    batch_vertex_count;
    logic [IDX_W-1:0]    batch_index_count;
    logic [STATE_W-1:0]  batch_state;
    logic                last;
  } out_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_DRAW,
    EMIT_VERT,
    EMIT_IDX
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      check_go;
    logic      rd_en;
    logic      place;
    logic      clear_step;
    emit_sel_e emit;
  } dp_cmd_t;

  typedef struct packed {
    logic draw_needed;
    logic clear_after;
    logic is_vertex;
    logic vert_pend;
    logic idx_more;
    logic idx_last;
    logic out_free;
    logic clear_last;
  } dp_status_t;

endpackage

// File: hdl/vib_ctrl.sv
// ----------------------------------------------------------------------------
// vib_ctrl
// sequencer: steps each input word through check, draw, table lookup and the
// serial emission of its result words
// ----------------------------------------------------------------------------
module vib_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vib_pkg::dp_status_t status_i,
  output vib_pkg::dp_cmd_t    cmd_o
);
  import vib_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DRAW,
    S_READ,
    S_PLACE,
    S_VERT,
    S_IDX
  } state_e;

  state_e state_q, state_d;
  logic   pending_q, pending_d;

  always_comb begin
    cmd_o      = '0;
    cmd_o.emit = EMIT_NONE;
    state_d    = state_q;
    pending_d  = pending_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d   = pending_q ? S_READ : S_IDLE;
          pending_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.draw_needed) begin
          state_d = S_DRAW;
        end else begin
          cmd_o.check_go = 1'b1;
          if (status_i.clear_after) begin
            state_d = S_CLEAR;
          end else if (status_i.is_vertex) begin
            state_d = S_PLACE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DRAW: begin
        if (status_i.out_free) begin
          cmd_o.emit     = EMIT_DRAW;
          cmd_o.check_go = 1'b1;
          if (status_i.clear_after) begin
            // table epoch wrapped: sweep before the lookup
            state_d   = S_CLEAR;
            pending_d = status_i.is_vertex;
          end else if (status_i.is_vertex) begin
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PLACE;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_VERT;
      end
      S_VERT: begin
        if (!status_i.vert_pend) begin
          state_d = S_IDX;
        end else if (status_i.out_free) begin
          cmd_o.emit = EMIT_VERT;
          state_d    = S_IDX;
        end
      end
      S_IDX: begin
        if (!status_i.idx_more) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = EMIT_IDX;
          if (status_i.idx_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// File: hdl/vib_datapath.sv
// ----------------------------------------------------------------------------
// vib_datapath
// batch counters, fan tracking, epoch-tagged remap memory and output register
// ----------------------------------------------------------------------------
module vib_datapath #(
  parameter int unsigned MAP_DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vib_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  vib_pkg::in_t               in_word_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output vib_pkg::out_t              out_word_o,
  input  vib_pkg::dp_cmd_t           cmd_i,
  output vib_pkg::dp_status_t        status_o
);
  import vib_pkg::*;

  localparam int unsigned MAP_ENTRIES = (MAP_DEPTH < (2 ** ID_W)) ? MAP_DEPTH : (2 ** ID_W);
  localparam int unsigned MAP_AW      = $clog2(MAP_ENTRIES);
  localparam int unsigned ENTRY_W     = EPOCH_W + SLOT_W;
  localparam logic [MESH_W-1:0] MAP_LIM =
    (MAP_DEPTH < (2 ** MESH_W) - 1) ? MESH_W'(MAP_DEPTH) : {MESH_W{1'b1}};
  localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_ENTRIES - 1);

  // remap memory: epoch tag and slot, entry valid when the tag matches
  logic [ENTRY_W-1:0] map_mem [MAP_ENTRIES];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we;
  logic [MAP_AW-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  in_t               item_q;
  logic [CAP_W-1:0]  vcap_q;
  logic [CAP_W-1:0]  used_v_q;
  logic [IDX_W-1:0]  used_i_q;
  logic [MESH_W-1:0] table_limit_q;
  logic [STATE_W-1:0] held_q;
  logic              held_valid_q;
  logic [SLOT_W-1:0] first_q;
  logic [SLOT_W-1:0] prev_q;
  logic [PV_W-1:0]   pos_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [MAP_AW-1:0] clr_cnt_q;
  logic              vert_q;
  logic [1:0]        n_emit_q;
  logic [1:0]        idx_cnt_q;
  logic [SLOT_W-1:0] idx_q [3];
  logic              out_valid_q;
  out_t              out_q;

  logic              is_vertex, is_mesh, is_flush;
  logic [CAP_W-1:0]  cap;
  logic [PV_W-1:0]   n_poly, n_tri;
  logic [4:0]        idx_need;
  logic [CAP_W:0]    vert_sum;
  logic [IDX_W:0]    idx_sum;
  logic              over_v, over_i, mismatch, draw_needed;
  logic [EPOCH_W-1:0] epoch_next;
  logic              epoch_max;
  logic [MESH_W-1:0] mesh_lim;
  logic              mapped, hit, full, new_ok, multi;
  logic [SLOT_W-1:0] full_slot, new_slot, slot_s;
  logic [1:0]        n_idx, n_emit;
  logic [IDX_W-1:0]  avail;
  logic              out_free;
  out_t              out_d;

  assign is_vertex = (item_q.cmd == CMD_VERTEX);
  assign is_mesh   = (item_q.cmd == CMD_MESH);
  assign is_flush  = (item_q.cmd == CMD_FLUSH);

  assign cap = (vcap_q < CAP_W'(VB_DEPTH)) ? vcap_q : CAP_W'(VB_DEPTH);

  // overflow test for the polygon that starts here
  always_comb begin
    if (item_q.poly_vertices < 4'd3) begin
      n_poly = 4'd3;
    end else if (item_q.poly_vertices > PV_W'(MAX_POLY)) begin
      n_poly = PV_W'(MAX_POLY);
    end else begin
      n_poly = item_q.poly_vertices;
    end
  end

  assign n_tri    = n_poly - 4'd2;
  assign idx_need = {n_tri, 1'b0} + 5'(n_tri);
  assign vert_sum = {1'b0, used_v_q} + (CAP_W+1)'(n_poly);
  assign idx_sum  = {1'b0, used_i_q} + (IDX_W+1)'(idx_need);
  assign over_v   = vert_sum > {1'b0, cap};
  assign over_i   = idx_sum > (IDX_W+1)'(IDX_LIMIT);
  assign mismatch = !held_valid_q || (held_q != item_q.render_state);

  // an empty batch is never drawn
  assign draw_needed = (used_v_q != '0) &&
                       (is_flush ||
                        (is_vertex && item_q.first_in_polygon && (mismatch || over_v || over_i)));

  assign epoch_max  = (epoch_q == {EPOCH_W{1'b1}});
  assign epoch_next = epoch_max ? EPOCH_W'(1) : epoch_q + 1'b1;
  assign mesh_lim   = (item_q.mesh_vertices < MAP_LIM) ? item_q.mesh_vertices : MAP_LIM;

  // slot choice for the vertex
  assign mapped    = item_q.in_table && ({1'b0, item_q.vertex_id} < table_limit_q);
  assign hit       = mapped && (rd_q[ENTRY_W-1:SLOT_W] == epoch_q);
  assign full      = (used_v_q >= cap);
  assign full_slot = (cap != '0) ? SLOT_W'(cap - 1'b1) : '0;
  assign new_slot  = full ? full_slot : used_v_q[SLOT_W-1:0];
  assign slot_s    = hit ? rd_q[SLOT_W-1:0] : new_slot;
  assign new_ok    = !hit && !full;
  assign multi     = (pos_q >= 4'd3);
  assign n_idx     = multi ? 2'd3 : 2'd1;
  assign avail     = IDX_W'(IDX_LIMIT) - used_i_q;
  assign n_emit    = (avail >= IDX_W'(n_idx)) ? n_idx : avail[1:0];

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_d = '0;
    case (cmd_i.emit)
      EMIT_DRAW: begin
        out_d.kind               = KIND_DRAW;
        out_d.batch_vertex_count = used_v_q;
        out_d.batch_index_count  = used_i_q;
        out_d.batch_state        = held_q;
        out_d.last               = is_flush;
      end
      EMIT_VERT: begin
        out_d.kind       = KIND_VERTEX;
        out_d.slot       = idx_q[2];
        out_d.handle_out = item_q.vertex_handle;
        out_d.last       = (n_emit_q == 2'd0);
      end
      EMIT_IDX: begin
        out_d.kind = KIND_INDEX;
        out_d.slot = idx_q[idx_cnt_q];
        out_d.last = (idx_cnt_q == n_emit_q - 2'd1);
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_q.vertex_id[MAP_AW-1:0];
    mem_wdata = {epoch_q, slot_s};
    if (cmd_i.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (cmd_i.place && mapped && new_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= map_mem[item_q.vertex_id[MAP_AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_word_i;
    end
    if (cmd_i.place) begin
      idx_q[0] <= multi ? first_q : slot_s;
      idx_q[1] <= prev_q;
      idx_q[2] <= slot_s;
    end
    if (cmd_i.emit != EMIT_NONE) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcap_q        <= CAP_RESET;
      used_v_q      <= '0;
      used_i_q      <= '0;
      table_limit_q <= '0;
      held_q        <= '0;
      held_valid_q  <= 1'b0;
      first_q       <= '0;
      prev_q        <= '0;
      pos_q         <= '0;
      epoch_q       <= EPOCH_W'(1);
      clr_cnt_q     <= '0;
      vert_q        <= 1'b0;
      n_emit_q      <= '0;
      idx_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcap_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_step) begin
        clr_cnt_q <= (clr_cnt_q == CLR_LAST) ? '0 : clr_cnt_q + 1'b1;
      end
      if (cmd_i.check_go) begin
        if (draw_needed) begin
          used_v_q <= '0;
          used_i_q <= '0;
        end
        if (is_vertex && item_q.first_in_polygon) begin
          pos_q <= '0;
          if (mismatch) begin
            held_q       <= item_q.render_state;
            held_valid_q <= 1'b1;
          end
        end
        if (is_mesh) begin
          table_limit_q <= mesh_lim;
        end
        // a batch draw or a new mesh invalidates the whole table
        if (draw_needed || is_mesh) begin
          epoch_q <= epoch_next;
        end
      end else if (cmd_i.place) begin
        vert_q    <= new_ok;
        n_emit_q  <= n_emit;
        idx_cnt_q <= '0;
        used_i_q  <= used_i_q + IDX_W'(n_emit);
        if (new_ok) begin
          used_v_q <= used_v_q + 1'b1;
        end
        if (pos_q == '0) begin
          first_q <= slot_s;
        end
        prev_q <= slot_s;
        if (pos_q != POS_MAX) begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (cmd_i.emit == EMIT_IDX) begin
        idx_cnt_q <= idx_cnt_q + 1'b1;
      end
      if (cmd_i.emit != EMIT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.draw_needed = draw_needed;
  assign status_o.clear_after = (draw_needed || is_mesh) && epoch_max;
  assign status_o.is_vertex   = is_vertex;
  assign status_o.vert_pend   = vert_q;
  assign status_o.idx_more    = (idx_cnt_q != n_emit_q);
  assign status_o.idx_last    = (idx_cnt_q == n_emit_q - 2'd1);
  assign status_o.out_free    = out_free;
  assign status_o.clear_last  = (clr_cnt_q == CLR_LAST);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hdl/vertex_index_batcher.sv
// a vertex word passes check, then draw and table read if it draws a batch,
// then place, vertex and index; a flush that draws passes check and draw,
// other commands check only; a full output register stalls the sequencer
// throughput: one word at a time, paced by the sequencer and the remap memory port
// reset: a sweep clears all min(MAP_DEPTH, 4096) remap memory entries, and
// the same sweep runs inside a word on every 255th table invalidation
// ----------------------------------------------------------------------------
// vertex_index_batcher
// turns polygon vertices into triangle-fan index words, vertex buffer words and
// batch draw words, with a remap table that shares buffer slots
// ----------------------------------------------------------------------------
module vertex_index_batcher #(
  parameter int unsigned MAP_DEPTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  vib_pkg::in_t              in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output vib_pkg::out_t             out_word_o,
  input  logic                      cfg_we_i,
  input  logic [vib_pkg::CAP_W-1:0] cfg_wdata_i
);
  import vib_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  vib_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  vib_datapath #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status)
  );

endmodule

// File: sim/vertex_index_batcher_checker.sv
// ----------------------------------------------------------------------------
// vertex_index_batcher_checker
// watches the word, result and configuration ports of the batcher, predicts
// the buffer writes and draw words each accepted word causes, and compares
// every accepted result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module vertex_index_batcher_checker #(
  parameter int unsigned MAP_DEPTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  vib_pkg::in_t              in_word_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  vib_pkg::out_t             out_word_i,
  input  logic                      cfg_we_i,
  input  logic [vib_pkg::CAP_W-1:0] cfg_wdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import vib_pkg::*;

  // shadow of the batcher state
  logic [CAP_W-1:0]   capacity;
  bit                 map_valid [MAP_DEPTH];
  logic [SLOT_W-1:0]  map_slot  [MAP_DEPTH];
  int unsigned        used_vtx;
  int unsigned        used_idx;
  int unsigned        table_limit;
  logic [STATE_W-1:0] held_state;
  bit                 held_valid;
  logic [SLOT_W-1:0]  fan_first;
  logic [SLOT_W-1:0]  fan_prev;
  int unsigned        fan_pos;

  out_t        word_writes[$];  // results of the word being predicted
  out_t        write_queue[$];  // results still to come from the block
  out_t        want;
  int unsigned result_no;
  int          mismatches;

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                result_no, name, got, exp_val));
    end
  endtask

  function automatic void clear_map();
    foreach (map_valid[i]) map_valid[i] = 1'b0;
  endfunction

  function automatic int unsigned cap_now();
    return (capacity < VB_DEPTH) ? capacity : VB_DEPTH;
  endfunction

  function automatic void emit(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [HANDLE_W-1:0] handle, int unsigned vcount,
                               int unsigned icount, logic [STATE_W-1:0] tag);
    out_t w;
    w.kind               = kind;
    w.slot               = slot;
    w.handle_out         = handle;
    w.batch_vertex_count = vcount[CAP_W-1:0];
    w.batch_index_count  = icount[IDX_W-1:0];
    w.batch_state        = tag;
    w.last               = 1'b0;
    word_writes.push_back(w);
  endfunction

  // an empty batch is never drawn
  function automatic void draw_batch();
    if (used_vtx == 0) return;
    emit(KIND_DRAW, '0, '0, used_vtx, used_idx, held_state);
    used_vtx = 0;
    used_idx = 0;
    clear_map();
  endfunction

  function automatic void index_write(logic [SLOT_W-1:0] slot);
    if (used_idx >= IDX_LIMIT) return;
    emit(KIND_INDEX, slot, '0, 0, 0, '0);
    used_idx++;
  endfunction

  // full buffer: last slot is reused and nothing is written
  function automatic logic [SLOT_W-1:0] claim_slot(logic [HANDLE_W-1:0] handle,
                                                   output bit ok);
    int unsigned       c;
    logic [SLOT_W-1:0] s;
    c = cap_now();
    if (used_vtx >= c) begin
      ok = 1'b0;
      return (c == 0) ? '0 : SLOT_W'(c - 1);
    end
    ok = 1'b1;
    s  = used_vtx[SLOT_W-1:0];
    emit(KIND_VERTEX, s, handle, 0, 0, '0);
    used_vtx++;
    return s;
  endfunction

  function automatic void compute_writes(in_t w);
    logic [SLOT_W-1:0] s;
    int unsigned       sides;
    int unsigned       lim;
    bit                drew;
    bit                ok;
    out_t              r;
    word_writes.delete();
    case (w.cmd)
      CMD_MESH: begin
        table_limit = (w.mesh_vertices < MAP_DEPTH) ? w.mesh_vertices : MAP_DEPTH;
        clear_map();
      end
      CMD_FLUSH: draw_batch();
      CMD_VERTEX: begin
        if (w.first_in_polygon) begin
          sides = w.poly_vertices;
          if (sides < 3) sides = 3;
          else if (sides > MAX_POLY) sides = MAX_POLY;
          drew = 1'b0;
          if (!held_valid || held_state != w.render_state) begin
            drew = (used_vtx != 0);
            draw_batch();
            held_state = w.render_state;
            held_valid = 1'b1;
          end
          // at most one draw per word
          if (!drew && (used_vtx + sides > cap_now() ||
                        used_idx + 3 * (sides - 2) > IDX_LIMIT)) begin
            draw_batch();
          end
          fan_pos = 0;
        end
        lim = (table_limit < MAP_DEPTH) ? table_limit : MAP_DEPTH;
        if (w.in_table && w.vertex_id < lim) begin
          if (map_valid[w.vertex_id]) begin
            s = map_slot[w.vertex_id];
          end else begin
            s = claim_slot(w.vertex_handle, ok);
            if (ok) begin
              map_valid[w.vertex_id] = 1'b1;
              map_slot[w.vertex_id]  = s;
            end
          end
        end else begin
          s = claim_slot(w.vertex_handle, ok);
        end
        if (fan_pos == 0) begin
          fan_first = s;
          fan_prev  = s;
          index_write(s);
        end else if (fan_pos < 3) begin
          fan_prev = s;
          index_write(s);
        end else begin
          index_write(fan_first);
          index_write(fan_prev);
          index_write(s);
          fan_prev = s;
        end
        if (fan_pos < POS_MAX) fan_pos++;
      end
      default: ;
    endcase
    foreach (word_writes[i]) begin
      r      = word_writes[i];
      r.last = (i == word_writes.size() - 1);
      write_queue.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity    = CAP_RESET;
      clear_map();
      used_vtx    = 0;
      used_idx    = 0;
      table_limit = 0;
      held_state  = '0;
      held_valid  = 1'b0;
      fan_first   = '0;
      fan_prev    = '0;
      fan_pos     = 0;
      result_no   = 0;
      mismatches  = 0;
      write_queue.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (in_valid_i && in_ready_i) compute_writes(in_word_i);
      if (out_valid_i && out_ready_i) begin
        if (write_queue.size() == 0) begin
          report_mismatch($sformatf("result %0d kind %0h slot %0h with nothing expected",
                                    result_no, out_word_i.kind, out_word_i.slot));
        end else begin
          want = write_queue.pop_front();
          check_field("kind", out_word_i.kind, want.kind);
          check_field("slot", out_word_i.slot, want.slot);
          check_field("handle_out", out_word_i.handle_out, want.handle_out);
          check_field("batch_vertex_count", out_word_i.batch_vertex_count,
                      want.batch_vertex_count);
          check_field("batch_index_count", out_word_i.batch_index_count,
                      want.batch_index_count);
          check_field("batch_state", out_word_i.batch_state, want.batch_state);
          check_field("last", out_word_i.last, want.last);
        end
        result_no++;
      end
      fail_count_o <= mismatches;
      pending_o    <= write_queue.size();
    end
  end

endmodule

// File: sim/vertex_index_batcher_tb.sv
// ----------------------------------------------------------------------------
// vertex_index_batcher_tb
// drives polygon, mesh and flush words into the batcher under several buffer
// capacities and idle patterns; the checker beside it predicts and compares
// ----------------------------------------------------------------------------
module vertex_index_batcher_tb;
  import vib_pkg::*;

  localparam int unsigned MAP_DEPTH     = 4096;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned FILL_WORDS    = 10;
  localparam int unsigned PHASE_WORDS   = 48;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_word;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  int unsigned        cycle_count   = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct     = 0;
  int                 fail_count;
  int                 pending_count;
  int                 fan_left      = 0;
  logic [STATE_W-1:0] tag_pool [4];
  logic [STATE_W-1:0] cur_tag;

  vertex_index_batcher #(.MAP_DEPTH(MAP_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  vertex_index_batcher_checker #(.MAP_DEPTH(MAP_DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_ready   <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_t vertex_word(bit first, logic [PV_W-1:0] n,
                                      logic [STATE_W-1:0] tag, bit tab,
                                      logic [ID_W-1:0] id, logic [HANDLE_W-1:0] handle);
    logic [127:0] noise;
    in_t          w;
    noise              = {$urandom, $urandom, $urandom, $urandom};
    w                  = noise[$bits(in_t)-1:0];
    w.cmd              = CMD_VERTEX;
    w.render_state     = tag;
    w.first_in_polygon = first;
    w.poly_vertices    = n;
    w.in_table         = tab;
    w.vertex_id        = id;
    w.vertex_handle    = handle;
    return w;
  endfunction

  // fields other than the mesh size are don't-care noise on commands
  function automatic in_t command_word(logic [CMD_W-1:0] cmd, logic [MESH_W-1:0] mesh);
    logic [127:0] noise;
    in_t          w;
    noise           = {$urandom, $urandom, $urandom, $urandom};
    w               = noise[$bits(in_t)-1:0];
    w.cmd           = cmd;
    w.mesh_vertices = mesh;
    return w;
  endfunction

  // mostly small ids so that slots get shared
  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(15) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(47));
  endfunction

  task automatic send(in_t w);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic start_polygon();
    logic [PV_W-1:0] n;
    int              sides;
    if ($urandom_range(4) == 0) begin
      cur_tag = ($urandom_range(3) == 0) ? $urandom : tag_pool[$urandom_range(3)];
    end
    n     = ($urandom_range(7) == 0) ? PV_W'($urandom) : PV_W'($urandom_range(3, MAX_POLY));
    sides = (n < 3) ? 3 : ((n > MAX_POLY) ? MAX_POLY : n);
    // now and then a long fan so the position saturates
    fan_left = sides - 1 + (($urandom_range(9) == 0) ? $urandom_range(14) : 0);
    send(vertex_word(1'b1, n, cur_tag, $urandom_range(9) != 0, pick_id(), $urandom));
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int idle_pct, int stall);
    int unsigned done;
    int unsigned r;
    bit          paused;
    done   = 0;
    paused = 1'b0;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (done < PHASE_WORDS) begin
      if (!paused && done >= PHASE_WORDS / 2) begin
        settle();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 5) begin
        send(command_word(CMD_MESH, ($urandom_range(3) == 0) ?
                                    MESH_W'($urandom) : MESH_W'($urandom_range(64))));
      end else if (r < 9) begin
        send(command_word(CMD_FLUSH, MESH_W'($urandom)));
      end else if (r < 11) begin
        // ignored word, not counted
        send(command_word(CMD_UNUSED, MESH_W'($urandom)));
        done--;
      end else if (r < 13) begin
        start_polygon();
      end else if (r < 16 || fan_left > 0) begin
        send(vertex_word(1'b0, PV_W'($urandom), $urandom, $urandom_range(9) != 0,
                         pick_id(), $urandom));
        if (fan_left > 0) fan_left--;
      end else begin
        start_polygon();
      end
      done++;
    end
  endtask

  initial begin
    tag_pool = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
    cur_tag  = tag_pool[2];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_capacity(CAP_RESET);

    // directed words
    send(command_word(CMD_FLUSH, '0));
    send(command_word(CMD_UNUSED, '1));
    send(command_word(CMD_MESH, 13'h1FFF));
    send(vertex_word(1'b1, 4'd0, 32'h0, 1'b1, 12'hFFF, 32'hFFFF_FFFF));
    send(vertex_word(1'b0, 4'd0, 32'h0, 1'b1, 12'h000, 32'h0000_0000));
    send(vertex_word(1'b0, 4'd0, 32'h0, 1'b1, 12'hFFF, 32'h1234_5678));
    send(vertex_word(1'b0, 4'd0, 32'h0, 1'b0, 12'hFFF, 32'hA5A5_A5A5));
    send(vertex_word(1'b1, 4'd15, 32'h0, 1'b1, 12'h000, 32'h5A5A_5A5A));
    send(vertex_word(1'b1, 4'd3, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 32'h0F0F_0F0F));
    send(vertex_word(1'b0, 4'd3, 32'hFFFF_FFFF, 1'b1, 12'h555, 32'hF0F0_F0F0));
    send(command_word(CMD_FLUSH, '0));
    send(command_word(CMD_FLUSH, '0));
    send(command_word(CMD_MESH, 13'd0));
    send(vertex_word(1'b1, 4'd4, 32'hFFFF_FFFF, 1'b1, 12'h000, $urandom));
    send(vertex_word(1'b0, 4'd4, 32'hFFFF_FFFF, 1'b1, 12'h000, $urandom));
    send(command_word(CMD_MESH, 13'd4096));
    send(vertex_word(1'b1, 4'd8, 32'hFFFF_FFFF, 1'b1, 12'hFFF, $urandom));
    send(vertex_word(1'b0, 4'd8, 32'hFFFF_FFFF, 1'b1, 12'hFFF, $urandom));
    send(command_word(CMD_FLUSH, '0));

    // one long fan over a few shared slots
    send(command_word(CMD_MESH, 13'd4096));
    send(vertex_word(1'b1, 4'd3, tag_pool[3], 1'b1, 12'd1, $urandom));
    repeat (FILL_WORDS) begin
      send(vertex_word(1'b0, PV_W'($urandom), $urandom, 1'b1,
                       ID_W'($urandom_range(3)), $urandom));
    end
    send(vertex_word(1'b1, 4'd3, tag_pool[3], 1'b1, 12'd1, $urandom));

    run_phase(CAP_W'(8), 0, 0);
    run_phase(CAP_W'(2047), 68, 0);
    run_phase(CAP_W'(5), 0, 68);
    run_phase(CAP_W'($urandom_range(8, 1024)), 33, 33);
    run_phase(CAP_W'(0), 68, 0);
    run_phase(CAP_W'(1024), 0, 68);
    run_phase(CAP_W'(64), 33, 33);

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
